FILE: hw/rtl/ptri_pkg.sv
package ptri_pkg;

  // Fixed-point layout
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 24;
  localparam int NORM_BITS = 30;

  // Tolerance compare: cross term scaled by 2^(2*UNIT_BITS - 2*FRAC_BITS)
  localparam int EDGE_SH = 2 * UNIT_BITS - 2 * FRAC_BITS;

  // Configuration registers
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_EPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL     = 1'd1;
  localparam logic [CFG_W-1:0] PARALLEL_EPS_RST = 25'd1678;
  localparam logic [CFG_W-1:0] EDGE_TOL_RST     = 25'd16777;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_z;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] height;
  } out_item_t;

endpackage

FILE: hw/rtl/point_height_on_triangle_core.sv
// Height of a triangle under a query point. Each request carries a query point (x, z) and
// three vertices; the block casts a ray straight down, builds the unit normal of the
// triangle (cross product, square root, three divides), rejects near-vertical planes
// against parallel_epsilon, and tests the hit against the three sides with edge_tolerance.
// It returns hit and the Q16.16 height (0 on a miss). Fully pipelined: one request per
// cycle while the output is not stalled; depth is set mostly by the restoring square root
// (16 stages), the normal dividers (13 stages) and the height divider (17 stages), two
// recurrence steps a stage. A stall at the output freezes the whole pipeline. Registers are
// written with cfg_write; write them only while no request is in flight.
module point_height_on_triangle_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ptri_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ptri_pkg::out_item_t               out_data,
  input  logic                              cfg_write,
  input  logic [ptri_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptri_pkg::CFG_W-1:0]        cfg_data
);
  import ptri_pkg::*;

  localparam int SQ_STEPS = NORM_BITS + 1;
  localparam int SQ_PER   = 2;
  localparam int SQ_ST    = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int ND_STEPS = UNIT_BITS + 1;
  localparam int ND_PER   = 2;
  localparam int ND_ST    = (ND_STEPS + ND_PER - 1) / ND_PER;
  localparam int HQ_W     = 34;
  localparam int HD_PER   = 2;
  localparam int HD_ST    = (HQ_W + HD_PER - 1) / HD_PER;
  localparam int DEPTH    = 8 + SQ_ST + ND_ST + 3 + HD_ST + 1;
  localparam int LW       = 68 + EDGE_SH + 1;

  // Payload carried from the normal scaling through the dividers
  typedef struct packed {
    logic [2:0]             nsg;
    logic                   zero;
    logic [2:0][NORM_BITS-1:0] nm;
    logic [2:0][66:0]       cr;
    logic [31:0]            ay;
    logic [32:0]            dqx;
    logic [32:0]            dqz;
  } ct_t;

  // Payload carried through the height divider
  typedef struct packed {
    logic        ovf;
    logic        qneg;
    logic        hit;
    logic [24:0] d;
    logic [31:0] ay;
  } ht_t;

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    sx = {v[31], v};
  endfunction

  logic [CFG_W-1:0] parallel_eps;
  logic [CFG_W-1:0] edge_tol;
  logic [DEPTH-1:0] vld;
  logic             adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_eps <= PARALLEL_EPS_RST;
      edge_tol     <= EDGE_TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PARALLEL_EPS: parallel_eps <= cfg_data;
        REG_EDGE_TOL:     edge_tol     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the output register can take data
  assign adv       = !vld[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: edge vectors and point offsets
  logic signed [32:0] s1_e1 [3];
  logic signed [32:0] s1_e2 [3];
  logic signed [32:0] s1_ebc_x, s1_ebc_z, s1_eca_x, s1_eca_z;
  logic signed [32:0] s1_dqx [3];
  logic signed [32:0] s1_dqz [3];
  logic [31:0]        s1_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e1[0]  <= sx(in_data.b_x) - sx(in_data.a_x);
      s1_e1[1]  <= sx(in_data.b_y) - sx(in_data.a_y);
      s1_e1[2]  <= sx(in_data.b_z) - sx(in_data.a_z);
      s1_e2[0]  <= sx(in_data.c_x) - sx(in_data.a_x);
      s1_e2[1]  <= sx(in_data.c_y) - sx(in_data.a_y);
      s1_e2[2]  <= sx(in_data.c_z) - sx(in_data.a_z);
      s1_ebc_x  <= sx(in_data.c_x) - sx(in_data.b_x);
      s1_ebc_z  <= sx(in_data.c_z) - sx(in_data.b_z);
      s1_eca_x  <= sx(in_data.a_x) - sx(in_data.c_x);
      s1_eca_z  <= sx(in_data.a_z) - sx(in_data.c_z);
      s1_dqx[0] <= sx(in_data.query_x) - sx(in_data.a_x);
      s1_dqx[1] <= sx(in_data.query_x) - sx(in_data.b_x);
      s1_dqx[2] <= sx(in_data.query_x) - sx(in_data.c_x);
      s1_dqz[0] <= sx(in_data.query_z) - sx(in_data.a_z);
      s1_dqz[1] <= sx(in_data.query_z) - sx(in_data.b_z);
      s1_dqz[2] <= sx(in_data.query_z) - sx(in_data.c_z);
      s1_ay     <= in_data.a_y;
    end
  end

  // Stage 2: partial products of the normal and of the cross terms of the three triangle sides
  logic signed [65:0] s2_np [6];
  logic signed [65:0] s2_cp [6];
  logic [31:0]        s2_ay;
  logic signed [32:0] s2_dqx, s2_dqz;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_np[0] <= s1_e1[1] * s1_e2[2];
      s2_np[1] <= s1_e1[2] * s1_e2[1];
      s2_np[2] <= s1_e1[2] * s1_e2[0];
      s2_np[3] <= s1_e1[0] * s1_e2[2];
      s2_np[4] <= s1_e1[0] * s1_e2[1];
      s2_np[5] <= s1_e1[1] * s1_e2[0];
      s2_cp[0] <= s1_dqz[0] * s1_e1[0];
      s2_cp[1] <= s1_dqx[0] * s1_e1[2];
      s2_cp[2] <= s1_dqz[1] * s1_ebc_x;
      s2_cp[3] <= s1_dqx[1] * s1_ebc_z;
      s2_cp[4] <= s1_dqz[2] * s1_eca_x;
      s2_cp[5] <= s1_dqx[2] * s1_eca_z;
      s2_ay    <= s1_ay;
      s2_dqx   <= s1_dqx[0];
      s2_dqz   <= s1_dqz[0];
    end
  end

  // Stage 3: exact differences
  logic signed [66:0] s3_n  [3];
  logic signed [66:0] s3_cr [3];
  logic [31:0]        s3_ay;
  logic signed [32:0] s3_dqx, s3_dqz;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_n[i]  <= 67'(s2_np[2*i]) - 67'(s2_np[2*i+1]);
        s3_cr[i] <= 67'(s2_cp[2*i]) - 67'(s2_cp[2*i+1]);
      end
      s3_ay  <= s2_ay;
      s3_dqx <= s2_dqx;
      s3_dqz <= s2_dqz;
    end
  end

  // Stage 4: sign and magnitude of the normal
  logic [2:0]         s4_nsg;
  logic [66:0]        s4_nmag [3];
  logic [2:0][66:0]   s4_cr;
  logic [31:0]        s4_ay;
  logic [32:0]        s4_dqx, s4_dqz;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_nsg[i]  <= s3_n[i][66];
        s4_nmag[i] <= s3_n[i][66] ? 67'(-s3_n[i]) : 67'(s3_n[i]);
        s4_cr[i]   <= s3_cr[i];
      end
      s4_ay  <= s3_ay;
      s4_dqx <= s3_dqx;
      s4_dqz <= s3_dqz;
    end
  end

  // Stage 5: scaling shift from the bit length of the largest component
  logic [66:0] s5_or;
  logic [6:0]  s5_blen;
  logic [5:0]  s5_sh;
  logic        s5_zero;
  logic [66:0] s5_nmag [3];
  logic [2:0]  s5_nsg;
  logic [2:0][66:0] s5_cr;
  logic [31:0] s5_ay;
  logic [32:0] s5_dqx, s5_dqz;

  always_comb begin
    s5_or   = s4_nmag[0] | s4_nmag[1] | s4_nmag[2];
    s5_blen = '0;
    for (int k = 0; k < 67; k++) begin
      if (s5_or[k]) s5_blen = 7'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sh   <= (s5_blen > 7'(NORM_BITS)) ? 6'(s5_blen - 7'(NORM_BITS)) : '0;
      s5_zero <= (s5_or == '0);
      for (int i = 0; i < 3; i++) s5_nmag[i] <= s4_nmag[i];
      s5_nsg  <= s4_nsg;
      s5_cr   <= s4_cr;
      s5_ay   <= s4_ay;
      s5_dqx  <= s4_dqx;
      s5_dqz  <= s4_dqz;
    end
  end

  // Stage 6: scaled magnitudes
  ct_t s6_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s6_c.nm[i] <= NORM_BITS'(s5_nmag[i] >> s5_sh);
      s6_c.nsg  <= s5_nsg;
      s6_c.zero <= s5_zero;
      s6_c.cr   <= s5_cr;
      s6_c.ay   <= s5_ay;
      s6_c.dqx  <= s5_dqx;
      s6_c.dqz  <= s5_dqz;
    end
  end

  // Stage 7: squares; stage 8: sum of squares
  logic [59:0] s7_sq [3];
  ct_t         s7_c;
  logic [61:0] s8_sum;
  ct_t         s8_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s7_sq[i] <= 60'(s6_c.nm[i]) * 60'(s6_c.nm[i]);
      s7_c   <= s6_c;
      s8_sum <= 62'(s7_sq[0]) + 62'(s7_sq[1]) + 62'(s7_sq[2]);
      s8_c   <= s7_c;
    end
  end

  // Square root: restoring, two result bits per stage
  logic [34:0] sq_rem  [SQ_ST];
  logic [30:0] sq_root [SQ_ST];
  logic [61:0] sq_rad  [SQ_ST];
  ct_t         sq_c    [SQ_ST];
  logic [34:0] sq_rem_next  [SQ_ST];
  logic [30:0] sq_root_next [SQ_ST];
  logic [61:0] sq_rad_next  [SQ_ST];
  ct_t         sq_c_next    [SQ_ST];

  always_comb begin
    logic [34:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
    logic [32:0] trial;
    for (int g = 0; g < SQ_ST; g++) begin
      if (g == 0) begin
        rem  = '0;
        root = '0;
        rad  = s8_sum;
        sq_c_next[g] = s8_c;
      end else begin
        rem  = sq_rem[g-1];
        root = sq_root[g-1];
        rad  = sq_rad[g-1];
        sq_c_next[g] = sq_c[g-1];
      end
      for (int k = 0; k < SQ_PER; k++) begin
        if (g * SQ_PER + k < SQ_STEPS) begin
          rem   = {rem[32:0], rad[61:60]};
          rad   = {rad[59:0], 2'b00};
          trial = {root, 2'b01};
          if (rem >= 35'(trial)) begin
            rem  = rem - 35'(trial);
            root = {root[29:0], 1'b1};
          end else begin
            root = {root[29:0], 1'b0};
          end
        end
      end
      sq_rem_next[g]  = rem;
      sq_root_next[g] = root;
      sq_rad_next[g]  = rad;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < SQ_ST; g++) begin
        sq_rem[g]  <= sq_rem_next[g];
        sq_root[g] <= sq_root_next[g];
        sq_rad[g]  <= sq_rad_next[g];
        sq_c[g]    <= sq_c_next[g];
      end
    end
  end

  // Normal divide: three lanes of restoring division by the length
  logic [31:0]          nd_rem [ND_ST][3];
  logic [UNIT_BITS:0]   nd_q   [ND_ST][3];
  logic [UNIT_BITS:0]   nd_nb  [ND_ST][3];
  logic [30:0]          nd_len [ND_ST];
  ct_t                  nd_c   [ND_ST];
  logic [31:0]          nd_rem_next [ND_ST][3];
  logic [UNIT_BITS:0]   nd_q_next   [ND_ST][3];
  logic [UNIT_BITS:0]   nd_nb_next  [ND_ST][3];
  logic [30:0]          nd_len_next [ND_ST];
  ct_t                  nd_c_next   [ND_ST];

  always_comb begin
    logic [31:0]        rem;
    logic [UNIT_BITS:0] q;
    logic [UNIT_BITS:0] nb;
    logic [30:0]        len;
    for (int g = 0; g < ND_ST; g++) begin
      if (g == 0) begin
        len          = sq_root[SQ_ST-1];
        nd_c_next[g] = sq_c[SQ_ST-1];
      end else begin
        len          = nd_len[g-1];
        nd_c_next[g] = nd_c[g-1];
      end
      nd_len_next[g] = len;
      for (int l = 0; l < 3; l++) begin
        if (g == 0) begin
          rem = 32'(sq_c[SQ_ST-1].nm[l] >> 1);
          nb  = {sq_c[SQ_ST-1].nm[l][0], UNIT_BITS'(0)};
          q   = '0;
        end else begin
          rem = nd_rem[g-1][l];
          nb  = nd_nb[g-1][l];
          q   = nd_q[g-1][l];
        end
        for (int k = 0; k < ND_PER; k++) begin
          if (g * ND_PER + k < ND_STEPS) begin
            rem = {rem[30:0], nb[UNIT_BITS]};
            nb  = {nb[UNIT_BITS-1:0], 1'b0};
            q   = {q[UNIT_BITS-1:0], 1'b0};
            if (rem >= 32'(len)) begin
              rem  = rem - 32'(len);
              q[0] = 1'b1;
            end
          end
        end
        nd_rem_next[g][l] = rem;
        nd_nb_next[g][l]  = nb;
        nd_q_next[g][l]   = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < ND_ST; g++) begin
        for (int l = 0; l < 3; l++) begin
          nd_rem[g][l] <= nd_rem_next[g][l];
          nd_q[g][l]   <= nd_q_next[g][l];
          nd_nb[g][l]  <= nd_nb_next[g][l];
        end
        nd_len[g] <= nd_len_next[g];
        nd_c[g]   <= nd_c_next[g];
      end
    end
  end

  // Stage NY: parallel reject, plane products, tolerance scale
  logic signed [UNIT_BITS+1:0] ny_nx, ny_nz;
  logic signed [33:0]          ny_axm, ny_azm;
  logic [UNIT_BITS:0]          ny_mag;
  ct_t                         ny_src;

  logic signed [59:0] s9_px, s9_pz;
  logic [49:0]        s9_rhs;
  logic               s9_rej, s9_nyneg;
  logic [24:0]        s9_d;
  logic [2:0][66:0]   s9_cr;
  logic [31:0]        s9_ay;

  always_comb begin
    ny_src = nd_c[ND_ST-1];
    ny_mag = nd_q[ND_ST-1][1];
    ny_nx  = ny_src.nsg[0] ? -$signed({1'b0, nd_q[ND_ST-1][0]})
                           :  $signed({1'b0, nd_q[ND_ST-1][0]});
    ny_nz  = ny_src.nsg[2] ? -$signed({1'b0, nd_q[ND_ST-1][2]})
                           :  $signed({1'b0, nd_q[ND_ST-1][2]});
    ny_axm = -34'($signed(ny_src.dqx));
    ny_azm = -34'($signed(ny_src.dqz));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_px    <= 60'(ny_nx) * 60'(ny_axm);
      s9_pz    <= 60'(ny_nz) * 60'(ny_azm);
      s9_rhs   <= 50'(edge_tol) * 50'(ny_mag);
      s9_rej   <= ny_src.zero || (ny_mag == '0) || (ny_mag < parallel_eps);
      s9_nyneg <= ny_src.nsg[1];
      s9_d     <= ny_mag;
      s9_cr    <= ny_src.cr;
      s9_ay    <= ny_src.ay;
    end
  end

  // Stage H2: plane numerator and the tests against the three triangle sides
  logic signed [60:0]   h2_num;
  logic signed [67:0]   h2_crs [3];
  logic signed [LW-1:0] h2_lhs [3];
  logic signed [LW-1:0] h2_rhs;
  logic [2:0]           h2_out;

  always_comb begin
    h2_num = 61'(s9_px) + 61'(s9_pz);
    h2_rhs = LW'($signed({1'b0, s9_rhs}));
    for (int i = 0; i < 3; i++) begin
      h2_crs[i] = s9_nyneg ? -68'($signed(s9_cr[i])) : 68'($signed(s9_cr[i]));
      h2_lhs[i] = LW'(h2_crs[i]) <<< EDGE_SH;
      h2_out[i] = h2_lhs[i] > h2_rhs;
    end
  end

  logic [60:0] h2_mag;
  logic        h2_qneg, h2_hit;
  logic [24:0] h2_d;
  logic [31:0] h2_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      h2_mag  <= h2_num[60] ? 61'(-h2_num) : 61'(h2_num);
      h2_qneg <= h2_num[60] ^ s9_nyneg;
      h2_hit  <= !s9_rej && (h2_out == '0);
      h2_d    <= s9_d;
      h2_ay   <= s9_ay;
    end
  end

  // Stage H3: quotient range check and divider set-up
  logic [25:0]     h3_rem;
  logic [HQ_W-1:0] h3_lb;
  ht_t             h3_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      h3_rem     <= 26'(h2_mag >> HQ_W);
      h3_lb      <= HQ_W'(h2_mag);
      h3_c.ovf   <= (h2_mag >> HQ_W) >= 61'(h2_d);
      h3_c.qneg  <= h2_qneg;
      h3_c.hit   <= h2_hit;
      h3_c.d     <= h2_d;
      h3_c.ay    <= h2_ay;
    end
  end

  // Height divide: |num| / |n_y|, restoring
  logic [25:0]     hd_rem [HD_ST];
  logic [HQ_W-1:0] hd_q   [HD_ST];
  logic [HQ_W-1:0] hd_lb  [HD_ST];
  ht_t             hd_c   [HD_ST];
  logic [25:0]     hd_rem_next [HD_ST];
  logic [HQ_W-1:0] hd_q_next   [HD_ST];
  logic [HQ_W-1:0] hd_lb_next  [HD_ST];
  ht_t             hd_c_next   [HD_ST];

  always_comb begin
    logic [25:0]     rem;
    logic [HQ_W-1:0] q;
    logic [HQ_W-1:0] lb;
    for (int g = 0; g < HD_ST; g++) begin
      if (g == 0) begin
        rem = h3_rem;
        lb  = h3_lb;
        q   = '0;
        hd_c_next[g] = h3_c;
      end else begin
        rem = hd_rem[g-1];
        lb  = hd_lb[g-1];
        q   = hd_q[g-1];
        hd_c_next[g] = hd_c[g-1];
      end
      for (int k = 0; k < HD_PER; k++) begin
        if (g * HD_PER + k < HQ_W) begin
          rem = {rem[24:0], lb[HQ_W-1]};
          lb  = {lb[HQ_W-2:0], 1'b0};
          q   = {q[HQ_W-2:0], 1'b0};
          if (rem >= 26'(hd_c_next[g].d)) begin
            rem  = rem - 26'(hd_c_next[g].d);
            q[0] = 1'b1;
          end
        end
      end
      hd_rem_next[g] = rem;
      hd_lb_next[g]  = lb;
      hd_q_next[g]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < HD_ST; g++) begin
        hd_rem[g] <= hd_rem_next[g];
        hd_q[g]   <= hd_q_next[g];
        hd_lb[g]  <= hd_lb_next[g];
        hd_c[g]   <= hd_c_next[g];
      end
    end
  end

  // Output: signed quotient plus a_y, saturated to 32 bits
  logic [HQ_W-1:0]      o_qv;
  logic signed [HQ_W:0] o_sq;
  logic signed [35:0]   o_sum;
  logic [31:0]          o_h;
  ht_t                  o_c;

  always_comb begin
    o_c   = hd_c[HD_ST-1];
    o_qv  = o_c.ovf ? '1 : hd_q[HD_ST-1];
    o_sq  = o_c.qneg ? -$signed({1'b0, o_qv}) : $signed({1'b0, o_qv});
    o_sum = 36'($signed(o_c.ay)) + 36'(o_sq);
    if (o_sum > 36'sd2147483647) begin
      o_h = 32'h7fff_ffff;
    end else if (o_sum < -36'sd2147483648) begin
      o_h = 32'h8000_0000;
    end else begin
      o_h = o_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hit    <= o_c.hit;
      out_data.height <= o_c.hit ? o_h : '0;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptri_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PARALLEL_EPS;
  logic [CFG_W-1:0] cfg_data = '0;

  point_height_on_triangle_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request queues and local copy of the registers
  in_item_t  pending_reqs[$];
  out_item_t expected_heights[$];
  logic [CFG_W-1:0] eps_cfg = PARALLEL_EPS_RST;
  logic [CFG_W-1:0] tol_cfg = EDGE_TOL_RST;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int errors = 0;
  logic req_taken = 1'b0;

  // a*b - c*d, exact
  function automatic logic signed [127:0] cross_wide(longint a, longint b, longint c,
                                                     longint d);
    logic signed [127:0] wa, wb, wc, wd;
    wa = a; wb = b; wc = c; wd = d;
    return wa * wb - wc * wd;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // true when the point lies outside the edge starting at (vx, vz)
  function automatic bit outside_edge(longint vx, longint vz, longint ex, longint ez,
                                      longint qx, longint qz, longint ny);
    logic signed [127:0] cr, rhs;
    longint any;
    cr = cross_wide(qz - vz, ex, qx - vx, ez);
    if (ny < 0) cr = -cr;
    any = (ny < 0) ? -ny : ny;
    rhs = longint'(tol_cfg) * any;
    rhs = rhs << (2 * FRAC_BITS);
    return (cr << (2 * UNIT_BITS)) > rhs;
  endfunction

  function automatic out_item_t predict_height(in_item_t p);
    longint x, z, ax, ay, az, bx, by, bz, cx, cy, cz;
    longint e1x, e1y, e1z, e2x, e2y, e2z, num, h, ny_mag;
    logic signed [127:0] nw[3];
    logic [127:0] mag[3], shifted;
    logic [63:0] nm[3], sum, len, q;
    longint n[3];
    int maxb, s;
    bit hit;
    out_item_t r;
    x = p.query_x; z = p.query_z;
    ax = p.a_x; ay = p.a_y; az = p.a_z;
    bx = p.b_x; by = p.b_y; bz = p.b_z;
    cx = p.c_x; cy = p.c_y; cz = p.c_z;
    e1x = bx - ax; e1y = by - ay; e1z = bz - az;
    e2x = cx - ax; e2y = cy - ay; e2z = cz - az;
    nw[0] = cross_wide(e1y, e2z, e1z, e2y);
    nw[1] = cross_wide(e1z, e2x, e1x, e2z);
    nw[2] = cross_wide(e1x, e2y, e1y, e2x);
    maxb = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (nw[i] < 0) ? -nw[i] : nw[i];
      for (int k = 0; k < 128; k++)
        if (mag[i][k] && k + 1 > maxb) maxb = k + 1;
    end
    hit = 1'b0;
    h = 0;
    // degenerate triangle gives a miss
    if (maxb != 0) begin
      s = (maxb > NORM_BITS) ? maxb - NORM_BITS : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        shifted = mag[i] >> s;
        nm[i] = shifted[63:0];
        sum = sum + nm[i] * nm[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (nm[i] << UNIT_BITS) / len;
        n[i] = (nw[i] < 0) ? -longint'(q) : longint'(q);
      end
      ny_mag = (n[1] < 0) ? -n[1] : n[1];
      if (n[1] != 0 && ny_mag >= longint'(eps_cfg)) begin
        num = n[0] * (ax - x) + n[2] * (az - z);
        h = ay + num / n[1];
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        hit = !outside_edge(ax, az, bx - ax, bz - az, x, z, n[1]) &&
              !outside_edge(bx, bz, cx - bx, cz - bz, x, z, n[1]) &&
              !outside_edge(cx, cz, ax - cx, az - cz, x, z, n[1]);
      end
    end
    r.hit = hit;
    r.height = hit ? h[31:0] : '0;
    return r;
  endfunction

  // Sender: new request at the falling edge once the last one was taken
  always @(posedge clk) req_taken <= in_valid && in_ready;

  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: check results, then predict accepted requests
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_heights.size() == 0) begin
          $display("%0t: unexpected result hit=%0b height=%0d", $time,
                   out_data.hit, out_data.height);
          errors++;
        end else begin
          want = expected_heights.pop_front();
          if (out_data.hit !== want.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time,
                     want.hit, out_data.hit);
            errors++;
          end
          if (out_data.height !== want.height) begin
            $display("%0t: height mismatch expected %0d actual %0d", $time,
                     want.height, out_data.height);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_heights.push_back(predict_height(in_data));
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint spread(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic in_item_t make_tri(longint qx, longint qz, longint ax, longint ay,
                                        longint az, longint bx, longint by, longint bz,
                                        longint cx, longint cy, longint cz);
    in_item_t t;
    t.query_x = qx[31:0]; t.query_z = qz[31:0];
    t.a_x = ax[31:0]; t.a_y = ay[31:0]; t.a_z = az[31:0];
    t.b_x = bx[31:0]; t.b_y = by[31:0]; t.b_z = bz[31:0];
    t.c_x = cx[31:0]; t.c_y = cy[31:0]; t.c_z = cz[31:0];
    return t;
  endfunction

  // Mostly sensible triangles with the query near them, some pure noise
  function automatic in_item_t random_tri();
    in_item_t t;
    longint r, ox, oz, ax, ay, az, bx, by, bz, cx, cy, cz, u, v, qx, qz;
    if ($urandom_range(0, 99) < 15) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
      return t;
    end
    case ($urandom_range(0, 3))
      0: r = 64'd1 << 10;
      1: r = 64'd1 << 18;
      2: r = 64'd1 << 24;
      default: r = 64'd1 << 30;
    endcase
    ox = spread(64'sd1 << 30); oz = spread(64'sd1 << 30);
    ax = ox + spread(r); az = oz + spread(r); ay = spread(64'sd1 << 30);
    bx = ox + spread(r); bz = oz + spread(r); by = ay + spread(r);
    cx = ox + spread(r); cz = oz + spread(r); cy = ay + spread(r);
    if ($urandom_range(0, 9) == 0) by = ay + spread(64'sd1 << 29) * 4;
    u = $urandom_range(0, 256);
    v = $urandom_range(0, 256 - u);
    qx = ax + ((bx - ax) * u + (cx - ax) * v) / 256;
    qz = az + ((bz - az) * u + (cz - az) * v) / 256;
    if ($urandom_range(0, 3) == 0) begin
      qx = qx + spread(r / 8 + 1);
      qz = qz + spread(r / 8 + 1);
    end
    return make_tri(qx, qz, ax, ay, az, bx, by, bz, cx, cy, cz);
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_heights.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_PARALLEL_EPS) eps_cfg = val;
    else tol_cfg = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  localparam longint ONE = 64'sd1 << 16;
  localparam longint MAXC = 64'sd2147483647;
  localparam longint MINC = -64'sd2147483648;

  initial begin
    logic [CFG_W-1:0] eps_set[6];
    logic [CFG_W-1:0] tol_set[6];
    bit hold_ph;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests under reset register values
    pending_reqs.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_tri(ONE, ONE, ONE, 5, ONE, ONE, 5, ONE, ONE, 5, ONE));
    pending_reqs.push_back(make_tri(ONE / 4, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_reqs.push_back(make_tri(ONE / 4, ONE / 4, 0, ONE, 0, ONE, ONE, 0, 0, ONE, ONE));
    pending_reqs.push_back(make_tri(0, 0, 0, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE, ONE));
    pending_reqs.push_back(make_tri(4 * ONE, 4 * ONE, 0, ONE, 0, ONE, ONE, 0, 0, ONE, ONE));
    pending_reqs.push_back(make_tri(ONE / 4, ONE / 4, 0, 0, 0, ONE, 0, ONE, 0, 0, ONE));
    pending_reqs.push_back(make_tri(ONE / 4, ONE / 4, 0, 0, 0, ONE, 100 * ONE, 0,
                                    0, 0, 1));
    pending_reqs.push_back(make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                    MAXC, MAXC, MAXC));
    pending_reqs.push_back(make_tri(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                                    MINC, MINC, MINC));
    pending_reqs.push_back(make_tri(0, 0, MINC, MINC, MINC, MAXC, MAXC, MINC,
                                    MINC, MAXC, MAXC));
    pending_reqs.push_back(make_tri(MAXC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC,
                                    MINC, MINC, MAXC));
    // heights near the top and the bottom of the range
    pending_reqs.push_back(make_tri(-ONE / 512, -ONE / 512, 0, MAXC - 16, 0, ONE, MAXC,
                                    0, 0, MAXC, ONE));
    pending_reqs.push_back(make_tri(-ONE / 512, -ONE / 512, 0, MINC + 16, 0, ONE, MINC,
                                    0, 0, MINC, ONE));
    drain();

    eps_set = '{25'd0, 25'h1FFFFFF, 25'd16777216, 25'd1, 25'd1678, 25'd0};
    tol_set = '{25'd0, 25'h1FFFFFF, 25'd16777216, 25'd16777, 25'd0, 25'h1FFFFFF};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_cfg(REG_PARALLEL_EPS, eps_set[ph]);
        write_cfg(REG_EDGE_TOL, tol_set[ph]);
      end else begin
        write_cfg(REG_PARALLEL_EPS, CFG_W'($urandom_range(0, 65535)));
        write_cfg(REG_EDGE_TOL, CFG_W'($urandom_range(0, 33554431)));
      end
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 54; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 54; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      hold_ph = (ph == 0 || ph == 5);
      // long output hold-off while the sender keeps pushing past the pipeline depth
      if (hold_ph) hold_seq++;
      repeat (hold_ph ? 80 : 30) pending_reqs.push_back(random_tri());
      // no more requests are queued until everything has come back
      drain();
      if (!hold_ph) begin
        repeat (30) pending_reqs.push_back(random_tri());
        drain();
      end
    end

    repeat (70) @(posedge clk);
    if (errors == 0 && expected_heights.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ptri_pkg.sv
hw/rtl/point_height_on_triangle_core.sv
tb/testbench.sv
